/* hdl/migration_metadata_decoder_top_defines.svh */
// Assertion macros for the decoder modules; mmd_queue is the one that uses them.
`ifndef MIGRATION_METADATA_DECODER_TOP_DEFINES_SVH
`define MIGRATION_METADATA_DECODER_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define MMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MMD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/mmd_pkg.sv */
package mmd_pkg;

  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_NAME     = 3'd1;
  localparam logic [2:0] KIND_ENTRY    = 3'd2;
  localparam logic [2:0] KIND_ACCEPTED = 3'd3;
  localparam logic [2:0] KIND_REJECTED = 3'd4;

  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_SHORT_HEADER  = 4'd1;
  localparam logic [3:0] ERR_BAD_VERSION   = 4'd2;
  localparam logic [3:0] ERR_TRUNC_NAMELEN = 4'd3;
  localparam logic [3:0] ERR_TRUNC_ENTRY   = 4'd4;
  localparam logic [3:0] ERR_MISSING_NAME  = 4'd5;
  localparam logic [3:0] ERR_ZERO_LENGTH   = 4'd6;
  localparam logic [3:0] ERR_RANGE         = 4'd7;
  localparam logic [3:0] ERR_TRAILING      = 4'd8;

  localparam logic [31:0] WANT_VERSION = 32'd1;
  localparam logic [3:0]  HEADER_LEN   = 4'd12;
  localparam logic [3:0]  WIDE_LEN     = 4'd8;
  localparam logic [3:0]  NARROW_LEN   = 4'd4;

  // Everything one input byte produces: an optional main record (header,
  // name byte or entry) and an optional closing record (accept or reject).
  typedef struct packed {
    logic        main_valid;
    logic [2:0]  main_kind;
    logic [7:0]  name_char;
    logic [31:0] generation_word;
    logic [63:0] region_offset;
    logic [63:0] region_length;
    logic [31:0] region_flags;
    logic [31:0] region_heat;
    logic [31:0] entry_total;
    logic [31:0] entry_number;
    logic        term_valid;
    logic [2:0]  term_kind;
    logic [3:0]  term_err;
  } mmd_item_t;

endpackage

/* hdl/migration_metadata_decoder_top.sv */
// A byte's first record is written into the queue and then into the output register, from which it is offered.
// Throughput: one byte per cycle while the queue has room (in_ready). A byte that closes
// a payload with a record of its own gives two output records; the two-entry queue hides
// that unless the next bytes bring records as well, which then holds the input back.
// Reset (rst, synchronous) returns the parser to the header and empties the
// queue and the output register.
module migration_metadata_decoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  record_kind,
  output logic [3:0]  error_code,
  output logic [7:0]  name_char,
  output logic [31:0] generation_word,
  output logic [31:0] entry_total,
  output logic [31:0] entry_number,
  output logic [63:0] region_offset,
  output logic [63:0] region_length,
  output logic [31:0] region_flags,
  output logic [31:0] region_heat,
  output logic        run_end
);
  import mmd_pkg::*;

  logic      accept;
  logic      push;
  mmd_item_t push_item;
  logic      full;
  logic      pop;
  logic      head_valid;
  mmd_item_t head_item;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  mmd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .push       (push),
    .push_item  (push_item)
  );

  mmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  mmd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .record_kind     (record_kind),
    .error_code      (error_code),
    .name_char       (name_char),
    .generation_word (generation_word),
    .entry_total     (entry_total),
    .entry_number    (entry_number),
    .region_offset   (region_offset),
    .region_length   (region_length),
    .region_flags    (region_flags),
    .region_heat     (region_heat),
    .run_end         (run_end)
  );

endmodule

/* hdl/mmd_front.sv */
module mmd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              final_byte,
  output logic              push,
  output mmd_pkg::mmd_item_t push_item
);
  import mmd_pkg::*;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_NAMELEN = 3'd1;
  localparam logic [2:0] PH_NAME    = 3'd2;
  localparam logic [2:0] PH_OFFSET  = 3'd3;
  localparam logic [2:0] PH_LENGTH  = 3'd4;
  localparam logic [2:0] PH_FLAGS   = 3'd5;
  localparam logic [2:0] PH_HEAT    = 3'd6;
  localparam logic [2:0] PH_DONE    = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [3:0]  byte_cnt, byte_cnt_next;
  logic [63:0] accum, accum_next;
  logic [31:0] announced, announced_next;
  logic [31:0] done_cnt, done_cnt_next;
  logic [7:0]  name_rem, name_rem_next;
  logic        name_empty, name_empty_next;
  logic        name_cut, name_cut_next;
  logic [63:0] held_offset, held_offset_next;
  logic [63:0] held_length, held_length_next;
  logic [31:0] held_flags, held_flags_next;
  logic        drop, drop_next;

  logic [63:0] accum_shift;
  logic [3:0]  cnt_inc;
  logic [31:0] done_inc;
  logic [7:0]  name_dec;
  logic        field_last;
  logic [3:0]  err;
  logic        clear;

  assign accum_shift = {accum[55:0], data_byte};
  assign cnt_inc     = byte_cnt + 4'd1;
  assign done_inc    = done_cnt + 32'd1;
  assign name_dec    = name_rem - 8'd1;
  assign field_last  = (phase <= PH_LENGTH) ? (cnt_inc >= WIDE_LEN) : (cnt_inc >= NARROW_LEN);

  always_comb begin
    phase_next       = phase;
    byte_cnt_next    = byte_cnt;
    accum_next       = accum;
    announced_next   = announced;
    done_cnt_next    = done_cnt;
    name_rem_next    = name_rem;
    name_empty_next  = name_empty;
    name_cut_next    = name_cut;
    held_offset_next = held_offset;
    held_length_next = held_length;
    held_flags_next  = held_flags;
    drop_next        = drop;
    err              = ERR_NONE;
    clear            = 1'b0;
    push_item        = '0;
    push_item.main_kind = KIND_HEADER;
    push_item.term_kind = KIND_REJECTED;
    push_item.term_err  = ERR_NONE;

    if (drop) begin
      // Everything else was cleared when the error was reported.
      if (final_byte) begin
        drop_next = 1'b0;
      end
    end else begin
      unique case (phase)
        PH_HEADER: begin
          accum_next    = accum_shift;
          byte_cnt_next = cnt_inc;
          if (cnt_inc == NARROW_LEN) begin
            // The version word is parked in the flags register.
            held_flags_next = accum_shift[31:0];
            accum_next      = '0;
          end else if (cnt_inc >= HEADER_LEN) begin
            announced_next  = accum_shift[31:0];
            held_flags_next = '0;
            accum_next      = '0;
            byte_cnt_next   = '0;
            if (held_flags != WANT_VERSION) begin
              err = ERR_BAD_VERSION;
            end else begin
              push_item.main_valid      = 1'b1;
              push_item.main_kind       = KIND_HEADER;
              push_item.generation_word = accum_shift[63:32];
              phase_next = (accum_shift[31:0] != '0) ? PH_NAMELEN : PH_DONE;
            end
          end
        end
        PH_NAMELEN: begin
          name_rem_next   = data_byte;
          name_empty_next = 1'b1;
          name_cut_next   = 1'b0;
          byte_cnt_next   = '0;
          accum_next      = '0;
          phase_next      = (data_byte != 8'd0) ? PH_NAME : PH_OFFSET;
        end
        PH_NAME: begin
          if (!name_cut) begin
            if (data_byte == 8'd0) begin
              name_cut_next = 1'b1;
            end else begin
              push_item.main_valid = 1'b1;
              push_item.main_kind  = KIND_NAME;
              push_item.name_char  = data_byte;
              name_empty_next      = 1'b0;
            end
          end
          name_rem_next = name_dec;
          if (name_dec == 8'd0) begin
            phase_next = PH_OFFSET;
          end
        end
        PH_OFFSET, PH_LENGTH, PH_FLAGS, PH_HEAT: begin
          accum_next    = accum_shift;
          byte_cnt_next = cnt_inc;
          if (field_last) begin
            accum_next    = '0;
            byte_cnt_next = '0;
            priority if (phase == PH_OFFSET) begin
              held_offset_next = accum_shift;
              phase_next       = PH_LENGTH;
            end else if (phase == PH_LENGTH) begin
              held_length_next = accum_shift;
              phase_next       = PH_FLAGS;
            end else if (phase == PH_FLAGS) begin
              held_flags_next = accum_shift[31:0];
              phase_next      = PH_HEAT;
            end else if (name_empty) begin
              err = ERR_MISSING_NAME;
            end else if (held_length == '0) begin
              err = ERR_ZERO_LENGTH;
            end else if (held_offset > ~held_length) begin
              // The sum would pass 2^64 - 1.
              err = ERR_RANGE;
            end else begin
              push_item.main_valid    = 1'b1;
              push_item.main_kind     = KIND_ENTRY;
              push_item.region_offset = held_offset;
              push_item.region_length = held_length;
              push_item.region_flags  = held_flags;
              push_item.region_heat   = accum_shift[31:0];
              done_cnt_next = done_inc;
              phase_next    = (done_inc == announced) ? PH_DONE : PH_NAMELEN;
            end
          end
        end
        default: begin
          err = ERR_TRAILING;
        end
      endcase

      push_item.entry_total  = announced_next;
      push_item.entry_number = done_cnt;

      if (err != ERR_NONE) begin
        push_item.term_valid = 1'b1;
        push_item.term_kind  = KIND_REJECTED;
        push_item.term_err   = err;
        clear                = 1'b1;
      end else if (final_byte) begin
        push_item.term_valid = 1'b1;
        clear                = 1'b1;
        unique case (phase_next)
          PH_HEADER: push_item.term_err = ERR_SHORT_HEADER;
          PH_NAMELEN: push_item.term_err = ERR_TRUNC_NAMELEN;
          PH_DONE: begin
            push_item.term_kind = KIND_ACCEPTED;
            push_item.term_err  = ERR_NONE;
          end
          default: push_item.term_err = ERR_TRUNC_ENTRY;
        endcase
      end

      if (clear) begin
        phase_next       = PH_HEADER;
        byte_cnt_next    = '0;
        accum_next       = '0;
        announced_next   = '0;
        done_cnt_next    = '0;
        name_rem_next    = '0;
        name_empty_next  = 1'b0;
        name_cut_next    = 1'b0;
        held_offset_next = '0;
        held_length_next = '0;
        held_flags_next  = '0;
        drop_next        = (err != ERR_NONE) && !final_byte;
      end
    end
  end

  assign push = accept && (push_item.main_valid || push_item.term_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      byte_cnt    <= '0;
      accum       <= '0;
      announced   <= '0;
      done_cnt    <= '0;
      name_rem    <= '0;
      name_empty  <= 1'b0;
      name_cut    <= 1'b0;
      held_offset <= '0;
      held_length <= '0;
      held_flags  <= '0;
      drop        <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      byte_cnt    <= byte_cnt_next;
      accum       <= accum_next;
      announced   <= announced_next;
      done_cnt    <= done_cnt_next;
      name_rem    <= name_rem_next;
      name_empty  <= name_empty_next;
      name_cut    <= name_cut_next;
      held_offset <= held_offset_next;
      held_length <= held_length_next;
      held_flags  <= held_flags_next;
      drop        <= drop_next;
    end
  end

endmodule

/* hdl/mmd_queue.sv */
`include "migration_metadata_decoder_top_defines.svh"

module mmd_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mmd_pkg::mmd_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output mmd_pkg::mmd_item_t head_item
);
  import mmd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mmd_item_t       slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            empty;

  assign empty      = (count == '0);
  assign full       = (count == CW'(DEPTH));
  assign head_valid = !empty;
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `MMD_ASSERT_ALWAYS(a_reset_empties, (rst |=> empty), "queue not empty after reset")
  `MMD_ASSERT(a_count_bound, (count <= CW'(DEPTH)), "queue count beyond depth")
  `MMD_ASSERT(a_no_pop_empty, (pop |-> !empty), "pop from empty queue")
  `MMD_ASSERT(a_push_fills, ((push && !pop) |=> !empty), "pushed item lost")

endmodule

/* hdl/mmd_back.sv */
module mmd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  mmd_pkg::mmd_item_t head_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         record_kind,
  output logic [3:0]         error_code,
  output logic [7:0]         name_char,
  output logic [31:0]        generation_word,
  output logic [31:0]        entry_total,
  output logic [31:0]        entry_number,
  output logic [63:0]        region_offset,
  output logic [63:0]        region_length,
  output logic [31:0]        region_flags,
  output logic [31:0]        region_heat,
  output logic               run_end
);
  import mmd_pkg::*;

  logic        second, second_next;
  logic        load;
  logic        take_main;
  logic [31:0] term_number;

  assign load      = !out_valid || out_ready;
  assign take_main = !second && head_item.main_valid;
  // A finished entry bumps the count before the closing record.
  assign term_number = head_item.entry_number +
      {31'd0, head_item.main_valid && (head_item.main_kind == KIND_ENTRY)};

  always_comb begin
    pop         = 1'b0;
    second_next = second;
    if (head_valid && load) begin
      if (take_main) begin
        if (head_item.term_valid) begin
          second_next = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        pop         = 1'b1;
        second_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      second <= second_next;
      if (load) begin
        out_valid <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      entry_total <= head_item.entry_total;
      if (take_main) begin
        record_kind     <= head_item.main_kind;
        error_code      <= ERR_NONE;
        name_char       <= head_item.name_char;
        generation_word <= head_item.generation_word;
        entry_number    <= head_item.entry_number;
        region_offset   <= head_item.region_offset;
        region_length   <= head_item.region_length;
        region_flags    <= head_item.region_flags;
        region_heat     <= head_item.region_heat;
        run_end         <= !head_item.term_valid;
      end else begin
        record_kind     <= head_item.term_kind;
        error_code      <= head_item.term_err;
        name_char       <= '0;
        generation_word <= '0;
        entry_number    <= term_number;
        region_offset   <= '0;
        region_length   <= '0;
        region_flags    <= '0;
        region_heat     <= '0;
        run_end         <= 1'b1;
      end
    end
  end

endmodule
